[rtl/ecdc_pkg.sv]
// ----------------------------------------------------------------------------
// ecdc_pkg
// Types, constants and the month offset table for the epoch / civil date-time
// converter (years 2000 to 2099).
// ----------------------------------------------------------------------------
package ecdc_pkg;

  localparam int STAGES = 9;

  localparam logic OP_TO_EPOCH = 1'b0;
  localparam logic OP_TO_CIVIL = 1'b1;

  localparam logic [31:0] FIRST_EPOCH = 32'd946684800;
  localparam logic [31:0] END_EPOCH   = 32'd4102444800;

  typedef struct packed {
    logic        opcode;
    logic [31:0] epoch_seconds;
    logic [6:0]  year_of_century;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ecdc_in_t;

  typedef struct packed {
    logic [31:0] epoch_out;
    logic [6:0]  year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        range_error;
  } ecdc_out_t;

  typedef struct packed {
    logic [STAGES-1:0] en;
    logic              op;
    logic              done;
  } ecdc_ctl_t;

  // first day of a march-based month, (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/ecdc_ctl.sv]
// ----------------------------------------------------------------------------
// ecdc_ctl
// Pipeline control: per-stage valid bits, stage enables with bubble removal,
// and the opcode carried alongside each item.
// ----------------------------------------------------------------------------
module ecdc_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_op,
  input  logic              rsp_stall,
  output ecdc_pkg::ecdc_ctl_t ctl
);
  import ecdc_pkg::*;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] vld_in;
  logic [STAGES-2:0] ops;
  logic [STAGES-2:0] op_in;
  logic [STAGES-1:0] en;

  assign vld_in = {vld[STAGES-2:0], req_valid};
  assign op_in  = {ops[STAGES-3:0], req_op};

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || !rsp_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES - 1; k++) begin
      if (en[k]) begin
        ops[k] <= op_in[k];
      end
    end
  end

  assign ctl.en   = en;
  assign ctl.op   = ops[STAGES-2];
  assign ctl.done = vld[STAGES-1];

endmodule

[rtl/ecdc_to_epoch.sv]
// ----------------------------------------------------------------------------
// ecdc_to_epoch
// Date and time to epoch seconds: range check and month offset, day number,
// day-to-seconds multiply, time-of-day add, then delay to the merge stage.
// ----------------------------------------------------------------------------
module ecdc_to_epoch (
  input  logic                clk,
  input  ecdc_pkg::ecdc_ctl_t ctl,
  input  ecdc_pkg::ecdc_in_t  din,
  output logic [31:0]         epoch,
  output logic                err
);
  import ecdc_pkg::*;

  localparam int DLY = STAGES - 5;

  logic [3:0]  mrot;
  logic        bad_s0;
  logic [6:0]  z_s0;
  logic [8:0]  dyr_s0;
  logic [16:0] tod_s0;

  logic        bad_s1;
  logic [15:0] dn_s1;
  logic [16:0] tod_s1;

  logic [32:0] dn_prod;
  logic        bad_s2;
  logic [31:0] prod_s2;
  logic [16:0] tod_s2;

  logic        bad_s3;
  logic [31:0] t_s3;

  logic [31:0] t_dly   [DLY];
  logic        bad_dly [DLY];

  assign mrot = (din.month > 4'd2) ? din.month - 4'd3 : din.month + 4'd9;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      bad_s0 <= (din.month == 4'd0) || (din.month > 4'd12) || (din.day == 5'd0) ||
                (din.year_of_century > 7'd99);
      z_s0   <= din.year_of_century + {6'd0, din.month > 4'd2};
      dyr_s0 <= month_start(mrot) + {4'd0, din.day} - 9'd1;
      tod_s0 <= 17'(din.hour) * 17'd3600 + 17'(din.minute) * 17'd60 + 17'(din.second);
    end
  end

  // days since 1970 with z counted from the march-based year 1999
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      bad_s1 <= bad_s0;
      dn_s1  <= 16'd10651 + 16'(z_s0) * 16'd365 + 16'((8'(z_s0) + 8'd3) >> 2) +
                16'(dyr_s0);
      tod_s1 <= tod_s0;
    end
  end

  assign dn_prod = 33'(dn_s1) * 33'd86400;

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      bad_s2  <= bad_s1;
      prod_s2 <= dn_prod[31:0];
      tod_s2  <= tod_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      bad_s3 <= bad_s2;
      t_s3   <= prod_s2 + 32'(tod_s2);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DLY; g++) begin : g_dly
      if (g == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (ctl.en[4]) begin
            t_dly[0]   <= t_s3;
            bad_dly[0] <= bad_s3;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (ctl.en[4+g]) begin
            t_dly[g]   <= t_dly[g-1];
            bad_dly[g] <= bad_dly[g-1];
          end
        end
      end
    end
  endgenerate

  assign epoch = t_dly[DLY-1];
  assign err   = bad_dly[DLY-1];

endmodule

[rtl/ecdc_to_civil.sv]
// ----------------------------------------------------------------------------
// ecdc_to_civil
// Epoch seconds to date and time: constant divisions by reciprocal multiply
// spread over the stages, then civil-from-days on 4-year cycles from 1996-03.
// ----------------------------------------------------------------------------
module ecdc_to_civil (
  input  logic                clk,
  input  ecdc_pkg::ecdc_ctl_t ctl,
  input  ecdc_pkg::ecdc_in_t  din,
  output logic [6:0]          year,
  output logic [3:0]          month,
  output logic [4:0]          day,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second,
  output logic                err
);
  import ecdc_pkg::*;

  logic        bad_s0, bad_s1, bad_s2, bad_s3, bad_s4, bad_s5, bad_s6, bad_s7;
  logic [31:0] e_s0;

  logic [50:0] q_prod;
  logic [15:0] q_s1;
  logic [24:0] x_s1;
  logic [6:0]  lo_s1;

  logic [24:0] p_s2;
  logic [15:0] dd_s2;
  logic [24:0] x_s2;
  logic [6:0]  lo_s2;

  logic [24:0] r_diff;
  logic [32:0] a_prod;
  logic [16:0] rem_s3;
  logic [4:0]  a_s3;
  logic [15:0] dd_s3;

  logic [34:0] h_prod;
  logic [4:0]  h_s4;
  logic [15:0] y0_s4;
  logic [16:0] rem_s4;
  logic [15:0] dd_s4;

  logic [16:0] rs_full;
  logic [32:0] y_prod;
  logic [11:0] rs_s5;
  logic [6:0]  yoe_s5;
  logic [4:0]  h_s5;
  logic [15:0] dd_s5;

  logic [24:0] m_prod;
  logic [15:0] doy_full;
  logic [5:0]  mi_s6;
  logic [8:0]  doy_s6;
  logic [4:0]  h_s6;
  logic [11:0] rs_s6;
  logic [6:0]  yoe_s6;

  logic [11:0] se_full;
  logic [10:0] doy5;
  logic [22:0] mp_prod;
  logic [5:0]  se_s7;
  logic [3:0]  mp_s7;
  logic [4:0]  h_s7;
  logic [5:0]  mi_s7;
  logic [6:0]  yoe_s7;
  logic [8:0]  doy_s7;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      bad_s0 <= (din.epoch_seconds < FIRST_EPOCH) || (din.epoch_seconds >= END_EPOCH);
      e_s0   <= din.epoch_seconds - FIRST_EPOCH;
    end
  end

  // days since 2000 = (e / 128) / 675
  assign q_prod = 51'(e_s0[31:7]) * 51'd50903317;

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      bad_s1 <= bad_s0;
      q_s1   <= q_prod[50:35];
      x_s1   <= e_s0[31:7];
      lo_s1  <= e_s0[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      bad_s2 <= bad_s1;
      p_s2   <= 25'(q_s1) * 25'd675;
      dd_s2  <= q_s1 + 16'd1401;
      x_s2   <= x_s1;
      lo_s2  <= lo_s1;
    end
  end

  assign r_diff = x_s2 - p_s2;
  assign a_prod = 33'(dd_s2) * 33'd91930;

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      bad_s3 <= bad_s2;
      rem_s3 <= {r_diff[9:0], lo_s2};
      a_s3   <= a_prod[31:27];
      dd_s3  <= dd_s2;
    end
  end

  assign h_prod = 35'(rem_s3) * 35'd149131;

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      bad_s4 <= bad_s3;
      h_s4   <= h_prod[33:29];
      y0_s4  <= dd_s3 - 16'(a_s3);
      rem_s4 <= rem_s3;
      dd_s4  <= dd_s3;
    end
  end

  assign rs_full = rem_s4 - 17'(h_s4) * 17'd3600;
  assign y_prod  = 33'(y0_s4) * 33'd91930;

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      bad_s5 <= bad_s4;
      rs_s5  <= rs_full[11:0];
      yoe_s5 <= y_prod[31:25];
      h_s5   <= h_s4;
      dd_s5  <= dd_s4;
    end
  end

  assign m_prod   = 25'(rs_s5) * 25'd4370;
  assign doy_full = dd_s5 - (16'(yoe_s5) * 16'd365 + 16'(yoe_s5[6:2]));

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      bad_s6 <= bad_s5;
      mi_s6  <= m_prod[23:18];
      doy_s6 <= doy_full[8:0];
      h_s6   <= h_s5;
      rs_s6  <= rs_s5;
      yoe_s6 <= yoe_s5;
    end
  end

  assign se_full = rs_s6 - 12'(mi_s6) * 12'd60;
  assign doy5    = 11'(doy_s6) * 11'd5 + 11'd2;
  assign mp_prod = 23'(doy5) * 23'd3427;

  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      bad_s7 <= bad_s6;
      se_s7  <= se_full[5:0];
      mp_s7  <= mp_prod[22:19];
      h_s7   <= h_s6;
      mi_s7  <= mi_s6;
      yoe_s7 <= yoe_s6;
      doy_s7 <= doy_s6;
    end
  end

  logic [8:0] dom_full;

  assign month    = (mp_s7 < 4'd10) ? mp_s7 + 4'd3 : mp_s7 - 4'd9;
  assign dom_full = doy_s7 - month_start(mp_s7) + 9'd1;
  assign day      = dom_full[4:0];
  assign year     = yoe_s7 + {6'd0, month <= 4'd2} - 7'd4;
  assign hour     = h_s7;
  assign minute   = mi_s7;
  assign second   = se_s7;
  assign err      = bad_s7;

endmodule

[rtl/epoch_civil_datetime_convert_unit.sv]
// ----------------------------------------------------------------------------
// epoch_civil_datetime_convert_unit
// Throughput: one item per cycle, set by the 9-stage pipeline, while the
// output is not stalled; bubbles close up so new items enter while a result
// waits on a stalled output.
// Reset clears the stage valid bits only; no other state is held.
// ----------------------------------------------------------------------------
module epoch_civil_datetime_convert_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ecdc_pkg::ecdc_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ecdc_pkg::ecdc_out_t rsp
);
  import ecdc_pkg::*;

  ecdc_ctl_t   ctl;
  logic [31:0] enc_epoch;
  logic        enc_err;
  logic [6:0]  dec_year;
  logic [3:0]  dec_month;
  logic [4:0]  dec_day;
  logic [4:0]  dec_hour;
  logic [5:0]  dec_minute;
  logic [5:0]  dec_second;
  logic        dec_err;
  ecdc_out_t   rsp_next;

  ecdc_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.opcode),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  ecdc_to_epoch u_enc (
    .clk   (clk),
    .ctl   (ctl),
    .din   (req),
    .epoch (enc_epoch),
    .err   (enc_err)
  );

  ecdc_to_civil u_dec (
    .clk    (clk),
    .ctl    (ctl),
    .din    (req),
    .year   (dec_year),
    .month  (dec_month),
    .day    (dec_day),
    .hour   (dec_hour),
    .minute (dec_minute),
    .second (dec_second),
    .err    (dec_err)
  );

  always_comb begin
    rsp_next = '0;
    if (ctl.op == OP_TO_EPOCH) begin
      rsp_next.range_error = enc_err;
      if (!enc_err) begin
        rsp_next.epoch_out = enc_epoch;
      end
    end else begin
      rsp_next.range_error = dec_err;
      if (!dec_err) begin
        rsp_next.year_out   = dec_year;
        rsp_next.month_out  = dec_month;
        rsp_next.day_out    = dec_day;
        rsp_next.hour_out   = dec_hour;
        rsp_next.minute_out = dec_minute;
        rsp_next.second_out = dec_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STAGES-1]) begin
      rsp <= rsp_next;
    end
  end

  assign rsp_valid = ctl.done;
  assign req_stall = !ctl.en[0];

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.range_error |->
      rsp.epoch_out == '0 && rsp.year_out == '0 && rsp.month_out == '0 &&
      rsp.day_out == '0 && rsp.hour_out == '0 && rsp.minute_out == '0 &&
      rsp.second_out == '0)
    else $error("range error with nonzero result fields");

  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.epoch_out != '0 |->
      rsp.month_out == '0 && rsp.day_out == '0 && !rsp.range_error)
    else $error("epoch and date fields both set");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled while output side can move");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

[sim/epoch_civil_datetime_convert_unit_tb.sv]
// ----------------------------------------------------------------------------
// epoch_civil_datetime_convert_unit_tb
// Self-checking bench for the epoch / civil date-time converter. A queue-fed
// driver sends date and epoch conversions with random gaps. A monitor predicts
// each accepted transfer and checks every result field in order. The output
// is stalled at random, between calm stretches.
// ----------------------------------------------------------------------------
module epoch_civil_datetime_convert_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecdc_pkg::*;

  localparam longint unsigned DAY_SECONDS = 64'd86400;
  localparam longint unsigned CIVIL_SHIFT = 64'd719468;
  localparam longint unsigned ERA_DAYS    = 64'd146097;
  localparam int              CENTURY_DAYS = 36525;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  ecdc_in_t  req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  ecdc_out_t rsp;

  ecdc_in_t  pending_q[$];
  ecdc_out_t expected_q[$];
  int        mismatches = 0;
  int        sent_count = 0;
  int        result_count = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  bit        req_fire = 1'b0;
  bit        rsp_fire = 1'b0;

  epoch_civil_datetime_convert_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // expected conversion of one request
  function automatic ecdc_out_t convert_datetime(ecdc_in_t it);
    ecdc_out_t       r;
    longint unsigned yr, yy, era, yoe, mrot, doy, doe, days, secs, rem, mp, mo;
    r = '0;
    if (it.opcode == OP_TO_EPOCH) begin
      if (it.month < 4'd1 || it.month > 4'd12 || it.day == 5'd0 ||
          it.year_of_century > 7'd99) begin
        r.range_error = 1'b1;
      end else begin
        yr   = 64'd2000 + it.year_of_century;
        yy   = yr - ((it.month <= 4'd2) ? 64'd1 : 64'd0);
        era  = yy / 64'd400;
        yoe  = yy - era * 64'd400;
        mrot = (it.month > 4'd2) ? (it.month - 64'd3) : (it.month + 64'd9);
        doy  = (64'd153 * mrot + 64'd2) / 64'd5 + it.day - 64'd1;
        doe  = yoe * 64'd365 + yoe / 64'd4 - yoe / 64'd100 + doy;
        days = era * ERA_DAYS + doe - CIVIL_SHIFT;
        secs = days * DAY_SECONDS + it.hour * 64'd3600 + it.minute * 64'd60 + it.second;
        r.epoch_out = secs[31:0];
      end
    end else begin
      if (it.epoch_seconds < FIRST_EPOCH || it.epoch_seconds >= END_EPOCH) begin
        r.range_error = 1'b1;
      end else begin
        days = it.epoch_seconds / DAY_SECONDS;
        rem  = it.epoch_seconds % DAY_SECONDS;
        days = days + CIVIL_SHIFT;
        era  = days / ERA_DAYS;
        doe  = days - era * ERA_DAYS;
        yoe  = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
        doy  = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
        mp   = (64'd5 * doy + 64'd2) / 64'd153;
        mo   = (mp < 64'd10) ? (mp + 64'd3) : (mp - 64'd9);
        yr   = yoe + era * 64'd400 + ((mo <= 64'd2) ? 64'd1 : 64'd0);
        secs = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
        r.day_out    = secs[4:0];
        r.month_out  = mo[3:0];
        yy           = yr - 64'd2000;
        r.year_out   = yy[6:0];
        secs         = rem / 64'd3600;
        r.hour_out   = secs[4:0];
        secs         = (rem % 64'd3600) / 64'd60;
        r.minute_out = secs[5:0];
        secs         = rem % 64'd60;
        r.second_out = secs[5:0];
      end
    end
    return r;
  endfunction

  // date request; the epoch field carries noise
  function automatic ecdc_in_t date_item(int yc, int mo, int dy, int hr, int mi, int se);
    ecdc_in_t it;
    it.opcode          = OP_TO_EPOCH;
    it.epoch_seconds   = $urandom();
    it.year_of_century = 7'(yc);
    it.month           = 4'(mo);
    it.day             = 5'(dy);
    it.hour            = 5'(hr);
    it.minute          = 6'(mi);
    it.second          = 6'(se);
    return it;
  endfunction

  // epoch request; the date fields carry noise
  function automatic ecdc_in_t epoch_item(logic [31:0] ep);
    ecdc_in_t    it;
    logic [95:0] noise;
    noise            = {$urandom(), $urandom(), $urandom()};
    it               = noise[$bits(ecdc_in_t)-1:0];
    it.opcode        = OP_TO_CIVIL;
    it.epoch_seconds = ep;
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  // monitor: predict accepted requests, check accepted results
  always @(posedge clk) begin
    ecdc_out_t want;
    req_fire = !rst && req_valid && !req_stall;
    rsp_fire = !rst && rsp_valid && !rsp_stall;
    if (req_fire)
      expected_q.push_back(convert_datetime(req));
    if (rsp_fire) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = expected_q.pop_front();
        check_field("epoch_out", rsp.epoch_out, want.epoch_out);
        check_field("year_out", 32'(rsp.year_out), 32'(want.year_out));
        check_field("month_out", 32'(rsp.month_out), 32'(want.month_out));
        check_field("day_out", 32'(rsp.day_out), 32'(want.day_out));
        check_field("hour_out", 32'(rsp.hour_out), 32'(want.hour_out));
        check_field("minute_out", 32'(rsp.minute_out), 32'(want.minute_out));
        check_field("second_out", 32'(rsp.second_out), 32'(want.second_out));
        check_field("range_error", 32'(rsp.range_error), 32'(want.range_error));
      end
      result_count++;
    end
  end

  // request driver with random gaps and calm stretches
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (gap_left > 0) begin
        req_valid <= 1'b0;
        gap_left--;
      end else if (pending_q.size() > 0) begin
        req       <= pending_q.pop_front();
        req_valid <= 1'b1;
        sent_count++;
        gap_left  = ((sent_count % 200) < 50) ? 0 : $urandom_range(0, 9);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // output stall: a fresh stall length after each result transfer
  always @(negedge clk) begin
    if (rsp_fire)
      stall_left = ((result_count % 150) < 40) ? 0 : $urandom_range(0, 9);
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    int          kind;
    logic [31:0] ep;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes and error cases
    pending_q.push_back(date_item(0, 1, 1, 0, 0, 0));
    pending_q.push_back(date_item(99, 12, 31, 23, 59, 59));
    pending_q.push_back(date_item(0, 2, 29, 12, 30, 30));
    pending_q.push_back(date_item(99, 2, 29, 1, 2, 3));
    pending_q.push_back(date_item(24, 2, 31, 0, 0, 0));
    pending_q.push_back(date_item(99, 12, 31, 31, 63, 63));
    pending_q.push_back(date_item(50, 6, 15, 31, 0, 0));
    pending_q.push_back(date_item(0, 0, 10, 0, 0, 0));
    pending_q.push_back(date_item(0, 13, 10, 0, 0, 0));
    pending_q.push_back(date_item(0, 15, 10, 0, 0, 0));
    pending_q.push_back(date_item(10, 5, 0, 0, 0, 0));
    pending_q.push_back(date_item(100, 5, 5, 0, 0, 0));
    pending_q.push_back(date_item(127, 15, 31, 31, 63, 63));
    pending_q.push_back(epoch_item(FIRST_EPOCH));
    pending_q.push_back(epoch_item(FIRST_EPOCH - 1));
    pending_q.push_back(epoch_item(END_EPOCH - 1));
    pending_q.push_back(epoch_item(END_EPOCH));
    pending_q.push_back(epoch_item(32'd0));
    pending_q.push_back(epoch_item(32'hFFFF_FFFF));
    pending_q.push_back(epoch_item(32'd951782400));
    pending_q.push_back(epoch_item(32'd951868799));
    pending_q.push_back(epoch_item(32'd1735689599));

    // hold off until the pipeline has drained
    while (pending_q.size() > 0 || req_valid || expected_q.size() > 0)
      @(posedge clk);

    for (int i = 0; i < 1450; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        pending_q.push_back(date_item($urandom_range(0, 99), $urandom_range(1, 12),
                                      $urandom_range(1, 31), $urandom_range(0, 23),
                                      $urandom_range(0, 59), $urandom_range(0, 59)));
      end else if (kind < 50) begin
        pending_q.push_back(date_item($urandom_range(0, 127), $urandom_range(0, 15),
                                      $urandom_range(0, 31), $urandom_range(0, 31),
                                      $urandom_range(0, 63), $urandom_range(0, 63)));
      end else if (kind < 75) begin
        pending_q.push_back(epoch_item($urandom_range(FIRST_EPOCH, END_EPOCH - 1)));
      end else if (kind < 90) begin
        // around midnight of a random day in the century
        ep = FIRST_EPOCH + $urandom_range(0, CENTURY_DAYS - 1) * 32'd86400;
        if ($urandom_range(0, 1))
          ep = ep + 32'd86399;
        pending_q.push_back(epoch_item(ep));
      end else begin
        pending_q.push_back(epoch_item($urandom()));
      end
    end

    while (pending_q.size() > 0 || req_valid || expected_q.size() > 0)
      @(posedge clk);
    repeat (STAGES + 20) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
